// ----- rtl/rgn_pkg.sv -----
// Package for the region free-list allocator: request/response beat types,
// status and kind codes, allocation grain and ALU flag struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rgn_pkg;

    // Request beat
    typedef struct packed {
        logic        kind;
        logic [47:0] req_length;
        logic [47:0] free_offset;
    } t_req;

    // Response beat
    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] grant_offset;
        logic [47:0] grant_length;
    } t_rsp;

    // Flags from the shared add/compare unit
    typedef struct packed {
        logic eq;   // a == b
        logic lt;   // a < b, valid on subtract
    } t_alu_flags;

    // Request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_NO_FIT  = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // Allocation lengths are multiples of 4 KiB
    localparam int GRAIN_BITS = 12;

    // External field width
    localparam int FIELD_BITS = 48;

endpackage

`default_nettype wire

// ----- rtl/region_free_list_allocator.sv -----
// Region free-list allocator: address-ordered free table in rgn_ram, walked one
//   entry per cycle around the shared rgn_alu; types from rgn_pkg.
// Paths: bad length; exact fit on the first pass; split of the first larger
//   region on the second pass, else no fit; free merge, full, or insert.
// Throughput: one beat at a time, the next taken the cycle after the result is
//   registered; a stalled response holds it off. Reset empties the table at once.
`timescale 1ns / 1ps
`default_nettype none

module region_free_list_allocator
    import rgn_pkg::*;
#(
    parameter int MAX_REGIONS = 16,
    parameter int ADDR_BITS   = 48
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output      logic o_req_stall,
    input  wire t_req i_req,
    output      logic o_rsp_valid,
    input  wire logic i_rsp_stall,
    output      t_rsp o_rsp
);

    localparam int AW = ADDR_BITS;
    localparam int IW = $clog2(MAX_REGIONS);
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REGIONS);

    // Sequencer states
    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_CHECK      = 4'd1;
    localparam logic [3:0] S_PRIME      = 4'd2;
    localparam logic [3:0] S_SCAN       = 4'd3;
    localparam logic [3:0] S_RM_PRIME   = 4'd4;
    localparam logic [3:0] S_RM         = 4'd5;
    localparam logic [3:0] S_SPLIT_OFF  = 4'd6;
    localparam logic [3:0] S_SPLIT_SIZE = 4'd7;
    localparam logic [3:0] S_MERGE      = 4'd8;
    localparam logic [3:0] S_INS_PRIME  = 4'd9;
    localparam logic [3:0] S_INS        = 4'd10;
    localparam logic [3:0] S_DONE       = 4'd11;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx,   n_idx;
    logic [CW-1:0] r_pos,   n_pos;
    logic          r_pass,  n_pass;
    logic          r_kind,  n_kind;
    logic [AW-1:0] r_len,   n_len;
    logic [AW-1:0] r_off,   n_off;
    logic [AW-1:0] r_end,   n_end;
    logic [AW-1:0] r_ent_off,  n_ent_off;
    logic [AW-1:0] r_ent_size, n_ent_size;
    logic [AW-1:0] r_tmp,   n_tmp;
    logic [1:0]    r_status, n_status;
    logic [AW-1:0] r_goff,  n_goff;
    logic [AW-1:0] r_glen,  n_glen;
    logic          r_rsp_valid, n_rsp_valid;
    t_rsp          r_rsp,   n_rsp;

    // RAM port signals
    logic            ram_we;
    logic [IW-1:0]   ram_waddr;
    logic [2*AW-1:0] ram_wdata;
    logic [IW-1:0]   ram_raddr;
    logic [2*AW-1:0] ram_rdata;

    // Shared ALU signals
    logic [AW-1:0] alu_a, alu_b, alu_res;
    logic          alu_sub;
    t_alu_flags    alu_flags;

    logic [AW-1:0] rd_off, rd_size;
    logic [CW-1:0] idx_p1, idx_p2, pos_m1, pos_m2, cnt_m1;
    logic [63:0]   len_wide, off_wide, goff_wide, glen_wide;

    assign rd_off  = ram_rdata[2*AW-1:AW];
    assign rd_size = ram_rdata[AW-1:0];
    assign idx_p1  = r_idx + CW'(1);
    assign idx_p2  = r_idx + CW'(2);
    assign pos_m1  = r_pos - CW'(1);
    assign pos_m2  = r_pos - CW'(2);
    assign cnt_m1  = r_count - CW'(1);

    // Input fields resized to the internal address width
    assign len_wide = 64'(i_req.req_length);
    assign off_wide = 64'(i_req.free_offset);
    // Grant fields masked back to the port width
    assign goff_wide = 64'(r_goff);
    assign glen_wide = 64'(r_glen);

    rgn_ram #(
        .WIDTH (2 * AW),
        .DEPTH (MAX_REGIONS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rgn_alu #(
        .W (AW)
    ) u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_res   (alu_res),
        .o_flags (alu_flags)
    );

    assign o_req_stall = (r_state != S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_pass      = r_pass;
        n_kind      = r_kind;
        n_len       = r_len;
        n_off       = r_off;
        n_end       = r_end;
        n_ent_off   = r_ent_off;
        n_ent_size  = r_ent_size;
        n_tmp       = r_tmp;
        n_status    = r_status;
        n_goff      = r_goff;
        n_glen      = r_glen;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid;

        ram_we    = 1'b0;
        ram_waddr = r_idx[IW-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = idx_p1[IW-1:0];

        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;

        // output register drains independently of the sequencer
        if (r_rsp_valid && !i_rsp_stall) begin
            n_rsp_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_kind   = i_req.kind;
                    n_len    = len_wide[AW-1:0];
                    n_off    = off_wide[AW-1:0];
                    n_status = ST_OK;
                    n_goff   = '0;
                    n_glen   = '0;
                    n_pass   = 1'b0;
                    n_state  = S_CHECK;
                end
            end

            S_CHECK: begin
                if (r_kind == KIND_ALLOC) begin
                    if (r_len == '0 || r_len[GRAIN_BITS-1:0] != '0) begin
                        n_status = ST_BAD_LEN;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_PRIME;
                    end
                end else begin
                    // end of the freed region
                    alu_a   = r_off;
                    alu_b   = r_len;
                    n_end   = alu_res;
                    n_state = S_PRIME;
                end
            end

            S_PRIME: begin
                ram_raddr = '0;
                n_idx     = '0;
                n_state   = S_SCAN;
            end

            // read data holds entry r_idx; next entry is being read
            S_SCAN: begin
                if (r_idx >= r_count) begin
                    if (r_kind == KIND_ALLOC) begin
                        if (!r_pass) begin
                            n_pass  = 1'b1;
                            n_state = S_PRIME;
                        end else begin
                            n_status = ST_NO_FIT;
                            n_state  = S_DONE;
                        end
                    end else if (r_count == MAX_CNT) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_INS_PRIME;
                    end
                end else begin
                    alu_sub = 1'b1;
                    if (r_kind == KIND_ALLOC && !r_pass) begin
                        // exact fit
                        alu_a = rd_size;
                        alu_b = r_len;
                        if (alu_flags.eq) begin
                            n_goff  = rd_off;
                            n_glen  = r_len;
                            n_state = S_RM_PRIME;
                        end else begin
                            n_idx = idx_p1;
                        end
                    end else if (r_kind == KIND_ALLOC) begin
                        // first larger region
                        alu_a = r_len;
                        alu_b = rd_size;
                        if (alu_flags.lt) begin
                            n_ent_off  = rd_off;
                            n_ent_size = rd_size;
                            n_goff     = rd_off;
                            n_glen     = r_len;
                            n_state    = S_SPLIT_OFF;
                        end else begin
                            n_idx = idx_p1;
                        end
                    end else begin
                        // free: merge forward or insert in address order
                        alu_a = r_end;
                        alu_b = rd_off;
                        if (alu_flags.eq) begin
                            n_ent_size = rd_size;
                            n_state    = S_MERGE;
                        end else if (alu_flags.lt) begin
                            if (r_count == MAX_CNT) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_INS_PRIME;
                            end
                        end else begin
                            n_idx = idx_p1;
                        end
                    end
                end
            end

            // remove entry r_idx: pull later entries down one a cycle
            S_RM_PRIME: begin
                ram_raddr = idx_p1[IW-1:0];
                n_state   = S_RM;
            end

            S_RM: begin
                if (idx_p1 >= r_count) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end else begin
                    ram_we    = 1'b1;
                    ram_waddr = r_idx[IW-1:0];
                    ram_wdata = ram_rdata;
                    ram_raddr = idx_p2[IW-1:0];
                    n_idx     = idx_p1;
                end
            end

            S_SPLIT_OFF: begin
                alu_a   = r_ent_off;
                alu_b   = r_len;
                n_tmp   = alu_res;
                n_state = S_SPLIT_SIZE;
            end

            S_SPLIT_SIZE: begin
                alu_a     = r_ent_size;
                alu_b     = r_len;
                alu_sub   = 1'b1;
                ram_we    = 1'b1;
                ram_waddr = r_idx[IW-1:0];
                ram_wdata = {r_tmp, alu_res};
                n_state   = S_DONE;
            end

            // merged entry starts at the freed offset
            S_MERGE: begin
                alu_a     = r_ent_size;
                alu_b     = r_len;
                ram_we    = 1'b1;
                ram_waddr = r_idx[IW-1:0];
                ram_wdata = {r_off, alu_res};
                n_state   = S_DONE;
            end

            // insert at r_idx: push entries up one a cycle from the top
            S_INS_PRIME: begin
                n_pos     = r_count;
                ram_raddr = cnt_m1[IW-1:0];
                n_state   = S_INS;
            end

            S_INS: begin
                ram_we = 1'b1;
                if (r_pos == r_idx) begin
                    ram_waddr = r_idx[IW-1:0];
                    ram_wdata = {r_off, r_len};
                    n_count   = r_count + CW'(1);
                    n_state   = S_DONE;
                end else begin
                    ram_waddr = r_pos[IW-1:0];
                    ram_wdata = ram_rdata;
                    ram_raddr = pos_m2[IW-1:0];
                    n_pos     = pos_m1;
                end
            end

            S_DONE: begin
                if (!r_rsp_valid || !i_rsp_stall) begin
                    n_rsp.status       = r_status;
                    n_rsp.grant_offset = goff_wide[FIELD_BITS-1:0];
                    n_rsp.grant_length = glen_wide[FIELD_BITS-1:0];
                    n_rsp_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_pass     <= n_pass;
        r_kind     <= n_kind;
        r_len      <= n_len;
        r_off      <= n_off;
        r_end      <= n_end;
        r_ent_off  <= n_ent_off;
        r_ent_size <= n_ent_size;
        r_tmp      <= n_tmp;
        r_status   <= n_status;
        r_goff     <= n_goff;
        r_glen     <= n_glen;
        r_rsp      <= n_rsp;
    end

    // Table never holds more than its capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("free table count above capacity");

    // Count moves only at the end of a remove or insert
    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            ($past(r_state) == S_RM || $past(r_state) == S_INS))
        else $error("free table count changed outside remove/insert");

    // An accepted beat starts the sequencer
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && !o_req_stall) |=> (r_state == S_CHECK))
        else $error("accepted request did not start the sequencer");

    // Failed requests and frees grant nothing; grants are whole pages
    a_grant_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |->
            ((o_rsp.status != ST_OK && o_rsp.grant_offset == '0 &&
              o_rsp.grant_length == '0) ||
             (o_rsp.status == ST_OK && o_rsp.grant_length[GRAIN_BITS-1:0] == '0)))
        else $error("response grant fields inconsistent with status");

endmodule

`default_nettype wire

// ----- rtl/rgn_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rgn_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/rgn_alu.sv -----
// Shared add/subtract/compare unit used by the allocator sequencer.
// Depends on rgn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rgn_alu
    import rgn_pkg::*;
#(
    parameter int W = 48
) (
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    input  wire logic         i_sub,
    output      logic [W-1:0] o_res,
    output      t_alu_flags   o_flags
);

    logic [W:0] sum;

    // a + b, or a - b as a + ~b + 1; carry out clear on subtract means borrow
    assign sum        = {1'b0, i_a} + {1'b0, (i_sub ? ~i_b : i_b)} + (W+1)'(i_sub);
    assign o_res      = sum[W-1:0];
    assign o_flags.lt = i_sub & ~sum[W];
    assign o_flags.eq = (i_a == i_b);

endmodule

`default_nettype wire

// ----- test/region_free_list_allocator_tb.sv -----
`timescale 1ns / 1ps
// Testbench for region_free_list_allocator: a directed table, then random allocate/free traffic.
// Each response is checked against the behavioral model or a typed row's expected response.
// Depends on rgn_pkg and the allocator RTL.

module region_free_list_allocator_tb;
    import rgn_pkg::*;

    localparam int MAX_REGIONS    = 16;
    localparam int CLK_HALF       = 2;
    localparam int RST_CYCLES     = 7;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 60;
    localparam int REPORT_MAX     = 10;

    // region handed out by a successful allocate, kept so it can be freed later
    typedef struct packed {
        logic [47:0] base;
        logic [47:0] span;
    } t_grant;

    // one row of the directed table; typed rows carry their own expected response
    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_dir_row;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_stall;
    t_req i_req       = '0;
    logic o_rsp_valid;
    logic i_rsp_stall = 1'b0;
    t_rsp o_rsp;

    // model of the free-region table
    logic [47:0] tbl_off  [MAX_REGIONS];
    logic [47:0] tbl_size [MAX_REGIONS];
    int          tbl_cnt = 0;

    t_rsp     outcome_q[$];
    t_grant   live_grants[$];
    t_dir_row dir_rows[$];

    bit req_idle_en  = 1'b0;
    bit rsp_idle_en  = 1'b0;
    bit rsp_hold_req = 1'b0;
    int fail_cnt     = 0;
    int quiet_cycles = 0;

    region_free_list_allocator #(
        .MAX_REGIONS (MAX_REGIONS),
        .ADDR_BITS   (48)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Apply one request beat to the table model and return the response it owes
    function automatic t_rsp table_apply(input t_req r);
        t_rsp        res;
        logic [47:0] len;
        logic [47:0] end_addr;
        bit          done;
        bit          add_entry;
        int          i;
        int          j;
        int          slot;
        res       = '0;
        done      = 1'b0;
        add_entry = 1'b0;
        slot      = tbl_cnt;
        len       = r.req_length;
        if (r.kind == KIND_ALLOC) begin
            if (len == '0 || len[GRAIN_BITS-1:0] != '0) begin
                res.status = ST_BAD_LEN;
            end else begin
                // exact fit first: the entry leaves the table
                for (i = 0; i < tbl_cnt && !done; i++) begin
                    if (tbl_size[i] == len) begin
                        res.grant_offset = tbl_off[i];
                        res.grant_length = len;
                        for (j = i; j + 1 < tbl_cnt; j++) begin
                            tbl_off[j]  = tbl_off[j+1];
                            tbl_size[j] = tbl_size[j+1];
                        end
                        tbl_cnt--;
                        done = 1'b1;
                    end
                end
                // otherwise the first larger region gives up its front
                for (i = 0; i < tbl_cnt && !done; i++) begin
                    if (tbl_size[i] > len) begin
                        res.grant_offset = tbl_off[i];
                        res.grant_length = len;
                        tbl_off[i]       = tbl_off[i] + len;
                        tbl_size[i]      = tbl_size[i] - len;
                        done             = 1'b1;
                    end
                end
                if (!done) begin
                    res.status = ST_NO_FIT;
                end
            end
        end else begin
            // forward merge into an entry starting at our end, else ordered insert
            end_addr = r.free_offset + len;
            for (i = 0; i < tbl_cnt && !done; i++) begin
                if (tbl_off[i] == end_addr) begin
                    tbl_size[i] = tbl_size[i] + len;
                    tbl_off[i]  = tbl_off[i] - len;
                    done        = 1'b1;
                end else if (end_addr < tbl_off[i]) begin
                    slot      = i;
                    add_entry = 1'b1;
                    done      = 1'b1;
                end
            end
            if (!done) begin
                add_entry = 1'b1;
            end
            if (add_entry) begin
                if (tbl_cnt >= MAX_REGIONS) begin
                    res.status = ST_FULL;
                end else begin
                    for (j = tbl_cnt; j > slot; j--) begin
                        tbl_off[j]  = tbl_off[j-1];
                        tbl_size[j] = tbl_size[j-1];
                    end
                    tbl_off[slot]  = r.free_offset;
                    tbl_size[slot] = len;
                    tbl_cnt++;
                end
            end
        end
        return res;
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    function automatic logic [47:0] page_len();
        return 48'($urandom_range(1, 16)) << GRAIN_BITS;
    endfunction

    // Random request: mostly page allocations and frees of live grants
    function automatic t_req pick_req();
        t_req   r;
        int     sel;
        int     k;
        t_grant g;
        r.kind        = KIND_ALLOC;
        r.req_length  = page_len();
        r.free_offset = rand48();
        sel           = $urandom_range(0, 99);
        if (sel < 45) begin
            // well-formed allocate, already set up
        end else if (sel < 80 && live_grants.size() > 0) begin
            k             = $urandom_range(0, live_grants.size() - 1);
            g             = live_grants[k];
            live_grants.delete(k);
            r.kind        = KIND_FREE;
            r.free_offset = g.base;
            r.req_length  = g.span;
        end else if (sel < 88) begin
            // fresh page-aligned capacity
            r.kind        = KIND_FREE;
            r.free_offset = 48'($urandom_range(0, 65535)) << GRAIN_BITS;
        end else if (sel < 95) begin
            // malformed allocate lengths
            case ($urandom_range(0, 2))
                0: r.req_length = '0;
                1: r.req_length = 48'($urandom_range(1, 4095));
                default: r.req_length = rand48();
            endcase
        end else begin
            // arbitrary free, may wrap the address space
            r.kind       = KIND_FREE;
            r.req_length = ($urandom_range(0, 7) == 0) ? '0 : rand48();
        end
        return r;
    endfunction

    function automatic void add_row(input logic k, input logic [47:0] len,
                                    input logic [47:0] off, input bit typed,
                                    input logic [1:0] st);
        t_dir_row row;
        row.req.kind        = k;
        row.req.req_length  = len;
        row.req.free_offset = off;
        row.typed           = typed;
        row.rsp             = '0;
        row.rsp.status      = st;
        dir_rows.push_back(row);
    endfunction

    // Offer one request beat, optionally after an idle burst, and log what it owes
    task automatic issue(input t_req r, input bit typed, input t_rsp typed_rsp,
                         output t_rsp pred);
        if (req_idle_en && $urandom_range(0, 5) == 0) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (o_req_stall);
        pred = table_apply(r);
        outcome_q.push_back(typed ? typed_rsp : pred);
    endtask

    task automatic run_random(input int n);
        t_req   r;
        t_rsp   pred;
        t_grant g;
        repeat (n) begin
            r = pick_req();
            issue(r, 1'b0, '0, pred);
            if (r.kind == KIND_ALLOC && pred.status == ST_OK) begin
                g.base = pred.grant_offset;
                g.span = pred.grant_length;
                live_grants.push_back(g);
            end
        end
    endtask

    // Hold the request side idle until every owed response has come back
    task automatic drain();
        i_req_valid <= 1'b0;
        do @(posedge i_clk); while (outcome_q.size() != 0);
    endtask

    task automatic check_rsp(input t_rsp got);
        t_rsp want;
        if (outcome_q.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_MAX) begin
                $display("%0t: unexpected response beat: status %0d offset %h length %h",
                         $time, got.status, got.grant_offset, got.grant_length);
            end
        end else begin
            want = outcome_q.pop_front();
            if (got.status !== want.status || got.grant_offset !== want.grant_offset ||
                got.grant_length !== want.grant_length) begin
                fail_cnt++;
                if (fail_cnt <= REPORT_MAX) begin
                    $display("%0t: mismatch: expected status %0d offset %h length %h",
                             $time, want.status, want.grant_offset, want.grant_length);
                    $display("%0t:           got      status %0d offset %h length %h",
                             $time, got.status, got.grant_offset, got.grant_length);
                end
            end
        end
    endtask

    // Response side: check accepted beats, then pick the next stall value
    initial begin
        int hold_left;
        int burst_left;
        hold_left  = 0;
        burst_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_rsp_valid && !i_rsp_stall) begin
                check_rsp(o_rsp);
            end
            if (rsp_hold_req) begin
                rsp_hold_req = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_rsp_stall <= 1'b1;
            end else if (burst_left > 0) begin
                burst_left--;
                i_rsp_stall <= 1'b1;
            end else if (rsp_idle_en && $urandom_range(0, 7) == 0) begin
                burst_left  = $urandom_range(0, 6);
                i_rsp_stall <= 1'b1;
            end else begin
                i_rsp_stall <= 1'b0;
            end
        end
    end

    // Watchdog: too long without a beat on either side
    always @(posedge i_clk) begin
        if ((i_req_valid && !o_req_stall) || (o_rsp_valid && !i_rsp_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Stimulus sequence
    initial begin
        t_rsp pred;
        int   k;
        // empty table, bad lengths at both extremes
        add_row(KIND_ALLOC, 48'h1000, '0, 1'b1, ST_NO_FIT);
        add_row(KIND_ALLOC, '0, '0, 1'b1, ST_BAD_LEN);
        add_row(KIND_ALLOC, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, ST_BAD_LEN);
        // seed, merge forward, no merge backward
        add_row(KIND_FREE, 48'h4_0000, 48'h10_0000, 1'b1, ST_OK);
        add_row(KIND_FREE, 48'h1_0000, 48'hF_0000, 1'b1, ST_OK);
        add_row(KIND_FREE, 48'h1000, 48'h14_0000, 1'b1, ST_OK);
        // exact fit, then split
        add_row(KIND_ALLOC, 48'h1000, 48'hFFFF_FFFF_FFFF, 1'b0, ST_OK);
        add_row(KIND_ALLOC, 48'h1_0000, '0, 1'b0, ST_OK);
        add_row(KIND_ALLOC, 48'hFFFF_FFFF_F000, '0, 1'b1, ST_NO_FIT);
        // zero-length free, wrapping free, duplicate free
        add_row(KIND_FREE, '0, '0, 1'b1, ST_OK);
        add_row(KIND_FREE, 48'h2000, 48'hFFFF_FFFF_F000, 1'b1, ST_OK);
        add_row(KIND_FREE, 48'h4_0000, 48'h10_0000, 1'b1, ST_OK);
        // fill the table, overflow it, then merge while full
        for (k = 1; k <= 12; k++) begin
            add_row(KIND_FREE, 48'h1000, 48'h20_0000 + 48'(k) * 48'h2_0000, 1'b1, ST_OK);
        end
        add_row(KIND_FREE, 48'h1000, 48'h40_0000, 1'b1, ST_FULL);
        add_row(KIND_FREE, 48'h1000, 48'h21_F000, 1'b1, ST_OK);
        add_row(KIND_ALLOC, 48'h1000, '0, 1'b0, ST_OK);

        req_idle_en = 1'b1;
        rsp_idle_en = 1'b1;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[n]) begin
            issue(dir_rows[n].req, dir_rows[n].typed, dir_rows[n].rsp, pred);
        end
        run_random(350);

        // sender pauses until everything is back
        drain();

        // long response hold-off while requests keep coming
        rsp_hold_req = 1'b1;
        req_idle_en  = 1'b0;
        run_random(100);
        req_idle_en  = 1'b1;
        run_random(300);

        // closing stretch at full rate
        req_idle_en = 1'b0;
        rsp_idle_en = 1'b0;
        run_random(100);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
